// File: src/tri2d_pkg.sv
// Shared widths, sideband types and arithmetic helpers for the 2D trilateration solver.
package tri2d_pkg;

	localparam int COORD_W = 32;
	localparam int RANGE_W = 31;
	localparam int DIFF_W  = 33;
	localparam int SQ_W    = 66;
	localparam int LIN_W   = 67;
	localparam int LO_W    = 34;
	localparam int NUM_W   = 102;
	localparam int DEN_W   = 68;
	localparam int DIV_W   = 104;
	localparam int Q_W     = 34;
	localparam int FRONT_LAT = 6;
	localparam int DIV_LAT   = Q_W + 1;
	localparam int LAT       = FRONT_LAT + DIV_LAT + 1;

	localparam logic signed [COORD_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] POS_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [COORD_W-1:0] base_x;
		logic signed [COORD_W-1:0] base_y;
		logic                      neg_x;
		logic                      neg_y;
		logic                      deg;
	} side_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] val;
		logic                      sat;
	} axis_t;

	// Rebuild a wide product from its high and low partial products.
	function automatic logic signed [NUM_W-1:0] combine(
		input logic signed [SQ_W-1:0] phi,
		input logic signed [LO_W+DIFF_W:0] plo
	);
		logic signed [NUM_W-1:0] h;
		logic signed [NUM_W-1:0] l;
		h = {{(NUM_W-SQ_W-LO_W){phi[SQ_W-1]}}, phi, {LO_W{1'b0}}};
		l = {{(NUM_W-LO_W-DIFF_W-1){plo[LO_W+DIFF_W]}}, plo};
		return h + l;
	endfunction

	// Apply the signed quotient to the base coordinate and clip.
	function automatic axis_t axis_solve(
		input logic signed [COORD_W-1:0] base,
		input logic [Q_W-1:0]            q,
		input logic                      ovf,
		input logic                      neg
	);
		axis_t r;
		logic signed [Q_W+1:0] mag;
		logic signed [Q_W+1:0] s;
		mag = $signed({2'b00, q});
		s = $signed({{(Q_W+2-COORD_W){base[COORD_W-1]}}, base}) + (neg ? -mag : mag);
		r.sat = 1'b0;
		if (ovf) begin
			r.val = neg ? POS_MIN : POS_MAX;
			r.sat = 1'b1;
		end else if (s > $signed({{(Q_W+2-COORD_W){1'b0}}, POS_MAX})) begin
			r.val = POS_MAX;
			r.sat = 1'b1;
		end else if (s < $signed({{(Q_W+2-COORD_W){1'b1}}, POS_MIN})) begin
			r.val = POS_MIN;
			r.sat = 1'b1;
		end else begin
			r.val = s[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: src/tri2d_front.sv
// Front pipeline: local differences, squares, linear terms, numerators and divider operands.
module tri2d_front
	import tri2d_pkg::*;
(
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [COORD_W-1:0] x1,
	input  logic signed [COORD_W-1:0] y1,
	input  logic signed [COORD_W-1:0] x2,
	input  logic signed [COORD_W-1:0] y2,
	input  logic signed [COORD_W-1:0] x3,
	input  logic signed [COORD_W-1:0] y3,
	input  logic [RANGE_W-1:0]        r1,
	input  logic [RANGE_W-1:0]        r2,
	input  logic [RANGE_W-1:0]        r3,
	output logic [DIV_W-1:0]          num_x,
	output logic [DIV_W-1:0]          num_y,
	output logic [DIV_W-1:0]          dvs,
	output side_t                     side
);

	// stage 1
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, ux_s1, uy_s1;
	logic [RANGE_W-1:0] r1_s1, r2_s1, r3_s1;
	logic signed [COORD_W-1:0] bx_s1, by_s1;
	// stage 2
	logic [2*RANGE_W-1:0] r1s_s2, r2s_s2, r3s_s2;
	logic signed [SQ_W-1:0] dxx_s2, dyy_s2, uxx_s2, uyy_s2, dxuy_s2, dyux_s2;
	logic signed [DIFF_W-1:0] dx_s2, dy_s2, ux_s2, uy_s2;
	logic signed [COORD_W-1:0] bx_s2, by_s2;
	// stage 3
	logic signed [LIN_W-1:0] a_s3, b_s3, c_s3;
	logic signed [DIFF_W-1:0] dx_s3, dy_s3, ux_s3, uy_s3;
	logic signed [COORD_W-1:0] bx_s3, by_s3;
	// stage 4
	logic signed [LO_W+DIFF_W:0] aluy_s4, bldy_s4, bldx_s4, alux_s4;
	logic signed [SQ_W-1:0] ahuy_s4, bhdy_s4, bhdx_s4, ahux_s4;
	logic signed [DEN_W-1:0] den_s4;
	logic deg_s4;
	logic signed [COORD_W-1:0] bx_s4, by_s4;
	// stage 5
	logic signed [NUM_W-1:0] nx_s5, ny_s5;
	logic signed [DEN_W-1:0] den_s5;
	logic deg_s5;
	logic signed [COORD_W-1:0] bx_s5, by_s5;

	logic signed [LO_W:0] alo, blo;
	logic signed [DIFF_W-1:0] ahi, bhi;
	logic [NUM_W-1:0] anx, any;
	logic [DEN_W-1:0] aden;

	assign alo = $signed({1'b0, a_s3[LO_W-1:0]});
	assign blo = $signed({1'b0, b_s3[LO_W-1:0]});
	assign ahi = a_s3[LIN_W-1:LO_W];
	assign bhi = b_s3[LIN_W-1:LO_W];
	assign anx = nx_s5[NUM_W-1] ? $unsigned(-nx_s5) : $unsigned(nx_s5);
	assign any = ny_s5[NUM_W-1] ? $unsigned(-ny_s5) : $unsigned(ny_s5);
	assign aden = den_s5[DEN_W-1] ? $unsigned(-den_s5) : $unsigned(den_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({x2[COORD_W-1], x2}) - $signed({x1[COORD_W-1], x1});
			dy_s1 <= $signed({y2[COORD_W-1], y2}) - $signed({y1[COORD_W-1], y1});
			ux_s1 <= $signed({x3[COORD_W-1], x3}) - $signed({x1[COORD_W-1], x1});
			uy_s1 <= $signed({y3[COORD_W-1], y3}) - $signed({y1[COORD_W-1], y1});
			r1_s1 <= r1;
			r2_s1 <= r2;
			r3_s1 <= r3;
			bx_s1 <= x1;
			by_s1 <= y1;

			r1s_s2 <= r1_s1 * r1_s1;
			r2s_s2 <= r2_s1 * r2_s1;
			r3s_s2 <= r3_s1 * r3_s1;
			dxx_s2 <= dx_s1 * dx_s1;
			dyy_s2 <= dy_s1 * dy_s1;
			uxx_s2 <= ux_s1 * ux_s1;
			uyy_s2 <= uy_s1 * uy_s1;
			dxuy_s2 <= dx_s1 * uy_s1;
			dyux_s2 <= dy_s1 * ux_s1;
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			ux_s2 <= ux_s1;
			uy_s2 <= uy_s1;
			bx_s2 <= bx_s1;
			by_s2 <= by_s1;

			a_s3 <= $signed({5'd0, r1s_s2}) - $signed({5'd0, r2s_s2})
				+ $signed({dxx_s2[SQ_W-1], dxx_s2}) + $signed({dyy_s2[SQ_W-1], dyy_s2});
			b_s3 <= $signed({5'd0, r1s_s2}) - $signed({5'd0, r3s_s2})
				+ $signed({uxx_s2[SQ_W-1], uxx_s2}) + $signed({uyy_s2[SQ_W-1], uyy_s2});
			c_s3 <= $signed({dxuy_s2[SQ_W-1], dxuy_s2}) - $signed({dyux_s2[SQ_W-1], dyux_s2});
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
			ux_s3 <= ux_s2;
			uy_s3 <= uy_s2;
			bx_s3 <= bx_s2;
			by_s3 <= by_s2;

			// split A and B so each multiplier stays near 34 x 33
			aluy_s4 <= alo * uy_s3;
			ahuy_s4 <= ahi * uy_s3;
			bldy_s4 <= blo * dy_s3;
			bhdy_s4 <= bhi * dy_s3;
			bldx_s4 <= blo * dx_s3;
			bhdx_s4 <= bhi * dx_s3;
			alux_s4 <= alo * ux_s3;
			ahux_s4 <= ahi * ux_s3;
			den_s4 <= {c_s3, 1'b0};
			deg_s4 <= (c_s3 == '0);
			bx_s4 <= bx_s3;
			by_s4 <= by_s3;

			nx_s5 <= combine(ahuy_s4, aluy_s4) - combine(bhdy_s4, bldy_s4);
			ny_s5 <= combine(bhdx_s4, bldx_s4) - combine(ahux_s4, alux_s4);
			den_s5 <= den_s4;
			deg_s5 <= deg_s4;
			bx_s5 <= bx_s4;
			by_s5 <= by_s4;

			// rounded quotient: (2|n| + |den|) / (2|den|)
			num_x <= {1'b0, anx, 1'b0} + {{(DIV_W-DEN_W){1'b0}}, aden};
			num_y <= {1'b0, any, 1'b0} + {{(DIV_W-DEN_W){1'b0}}, aden};
			dvs <= {{(DIV_W-DEN_W-1){1'b0}}, aden, 1'b0};
			side.base_x <= bx_s5;
			side.base_y <= by_s5;
			side.neg_x <= nx_s5[NUM_W-1] ^ den_s5[DEN_W-1];
			side.neg_y <= ny_s5[NUM_W-1] ^ den_s5[DEN_W-1];
			side.deg <= deg_s5;
		end
	end

endmodule

// File: src/tri2d_div.sv
// Pipelined restoring divider: one quotient bit per stage plus an overflow check.
module tri2d_div
	import tri2d_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] dvs,
	output logic [Q_W-1:0]   q,
	output logic             ovf
);

	logic [DIV_W-1:0] rem_s [Q_W];
	logic [DIV_W-1:0] dv_s  [Q_W];
	logic [Q_W-1:0]   q_s   [Q_W+1];
	logic             ovf_s [Q_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			dv_s[0]  <= dvs;
			q_s[0]   <= '0;
			ovf_s[0] <= (num >= (dvs << Q_W));
		end
	end

	for (genvar i = 0; i < Q_W; i++) begin : g_step
		localparam int K = Q_W - 1 - i;
		logic [DIV_W-1:0] shd;
		logic             take;
		assign shd  = dv_s[i] << K;
		assign take = (rem_s[i] >= shd);
		always_ff @(posedge clk) begin
			if (en) begin
				// bit K is still clear here; set it from this stage's compare
				q_s[i+1]    <= q_s[i] | ({{(Q_W-1){1'b0}}, take} << K);
				ovf_s[i+1]  <= ovf_s[i];
			end
		end
		if (i < Q_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1] <= take ? rem_s[i] - shd : rem_s[i];
					dv_s[i+1]  <= dv_s[i];
				end
			end
		end
	end

	assign q   = q_s[Q_W];
	assign ovf = ovf_s[Q_W];

endmodule

// File: src/trilateration_2d_solver.sv
// An accepted input beat passes through the front pipeline, the divider and the output register to its result beat.
// Throughput: one beat per cycle; the whole pipe advances together, held only by out_stall.
// Depth is set by the 34-stage restoring divider, one quotient bit per stage, per axis.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
// Degenerate geometry (collinear or coincident anchors) returns zero with degenerate set.
// Top level: 2D trilateration solver from three anchors and three ranges.
module trilateration_2d_solver
	import tri2d_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] anchor_one_x,
	input  logic signed [COORD_W-1:0] anchor_one_y,
	input  logic signed [COORD_W-1:0] anchor_two_x,
	input  logic signed [COORD_W-1:0] anchor_two_y,
	input  logic signed [COORD_W-1:0] anchor_three_x,
	input  logic signed [COORD_W-1:0] anchor_three_y,
	input  logic [RANGE_W-1:0]        range_one,
	input  logic [RANGE_W-1:0]        range_two,
	input  logic [RANGE_W-1:0]        range_three,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [COORD_W-1:0] position_x,
	output logic signed [COORD_W-1:0] position_y,
	output logic                      degenerate,
	output logic                      saturated
);

	// Advance every stage unless a finished beat is held at the output.
	logic en;
	logic [LAT-1:0] vld_s;

	logic [DIV_W-1:0] num_x, num_y, dvs;
	side_t side;
	side_t side_s [DIV_LAT];
	logic [Q_W-1:0] qx, qy;
	logic ovfx, ovfy;
	axis_t ax, ay;

	assign en = !out_valid || !out_stall;
	assign in_stall = !en;
	assign out_valid = vld_s[LAT-1];

	// Valid bits travel with the data; a bubble enters when no input beat is offered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	tri2d_front u_front (
		.clk   (clk),
		.en    (en),
		.x1    (anchor_one_x),
		.y1    (anchor_one_y),
		.x2    (anchor_two_x),
		.y2    (anchor_two_y),
		.x3    (anchor_three_x),
		.y3    (anchor_three_y),
		.r1    (range_one),
		.r2    (range_two),
		.r3    (range_three),
		.num_x (num_x),
		.num_y (num_y),
		.dvs   (dvs),
		.side  (side)
	);

	tri2d_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (num_x),
		.dvs (dvs),
		.q   (qx),
		.ovf (ovfx)
	);

	tri2d_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (num_y),
		.dvs (dvs),
		.q   (qy),
		.ovf (ovfy)
	);

	// Hold base coordinates and signs alongside the divider stages.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side;
			for (int i = 1; i < DIV_LAT; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	always_comb begin
		ax = axis_solve(side_s[DIV_LAT-1].base_x, qx, ovfx, side_s[DIV_LAT-1].neg_x);
		ay = axis_solve(side_s[DIV_LAT-1].base_y, qy, ovfy, side_s[DIV_LAT-1].neg_y);
	end

	// Output stage: drop the quotient on degenerate geometry.
	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s[DIV_LAT-1].deg) begin
				position_x <= '0;
				position_y <= '0;
				saturated  <= 1'b0;
				degenerate <= 1'b1;
			end else begin
				position_x <= ax.val;
				position_y <= ay.val;
				saturated  <= ax.sat | ay.sat;
				degenerate <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_deg_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> !saturated && position_x == '0 && position_y == '0)
		else $error("degenerate result carries data");

	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> position_x == POS_MAX || position_x == POS_MIN
			|| position_y == POS_MAX || position_y == POS_MIN)
		else $error("saturated flag without a clipped coordinate");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output is free");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("pipeline valid bits moved during a stall");
`endif

endmodule

// File: tb/sv/tb.sv
// Testbench for trilateration_2d_solver: random and directed anchor sets checked against a predictor.
`timescale 1ns / 100ps

module tb;
	import tri2d_pkg::*;

	// One anchor set with its three ranges; hold_drain makes the driver wait for an empty pipe.
	typedef struct {
		logic signed [COORD_W-1:0] ax1, ay1, ax2, ay2, ax3, ay3;
		logic [RANGE_W-1:0]        r1, r2, r3;
		logic                      hold_drain;
	} anchor_set_t;

	typedef struct {
		logic signed [COORD_W-1:0] px, py;
		logic                      deg, sat;
	} fix_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [COORD_W-1:0] anchor_one_x, anchor_one_y, anchor_two_x, anchor_two_y;
	logic signed [COORD_W-1:0] anchor_three_x, anchor_three_y;
	logic [RANGE_W-1:0] range_one, range_two, range_three;
	logic out_valid;
	logic out_stall;
	logic signed [COORD_W-1:0] position_x, position_y;
	logic degenerate, saturated;

	anchor_set_t pending_sets[$];
	fix_t        expected_fixes[$];
	int          mismatches;
	int          sent_sets;
	int          queued_sets;
	int          send_gap;
	int          stall_left;
	int          stall_draw;
	logic        burst_mode;
	logic        last_seen;
	logic        in_fire;

	trilateration_2d_solver uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.anchor_one_x(anchor_one_x), .anchor_one_y(anchor_one_y),
		.anchor_two_x(anchor_two_x), .anchor_two_y(anchor_two_y),
		.anchor_three_x(anchor_three_x), .anchor_three_y(anchor_three_y),
		.range_one(range_one), .range_two(range_two), .range_three(range_three),
		.out_valid(out_valid), .out_stall(out_stall),
		.position_x(position_x), .position_y(position_y),
		.degenerate(degenerate), .saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Round num/den to nearest (ties away from zero), add to base, clip to 32 bits.
	function automatic logic signed [COORD_W-1:0] place_axis(
		input logic signed [127:0] base,
		input logic signed [127:0] num,
		input logic signed [127:0] den,
		inout logic                clipped
	);
		logic [127:0]        mag_n;
		logic [127:0]        mag_d;
		logic [127:0]        quo;
		logic                neg;
		logic signed [127:0] v;
		neg = num[127] ^ den[127];
		mag_n = num[127] ? -num : num;
		mag_d = den[127] ? -den : den;
		quo = (2 * mag_n + mag_d) / (2 * mag_d);
		if (quo >= (128'd1 << 62)) begin
			clipped = 1'b1;
			return neg ? POS_MIN : POS_MAX;
		end
		v = neg ? base - $signed(quo) : base + $signed(quo);
		if (v > 128'sh7FFF_FFFF) begin
			clipped = 1'b1;
			return POS_MAX;
		end
		if (v < -128'sh8000_0000) begin
			clipped = 1'b1;
			return POS_MIN;
		end
		return v[COORD_W-1:0];
	endfunction

	// Closed-form local-frame solution: exact products, only the two divisions round.
	function automatic fix_t solve_position(input anchor_set_t s);
		logic signed [127:0] x1, y1, dx, dy, ux, uy, q1, q2, q3, a, b, c;
		fix_t f;
		x1 = s.ax1;
		y1 = s.ay1;
		dx = 128'(s.ax2) - x1;
		dy = 128'(s.ay2) - y1;
		ux = 128'(s.ax3) - x1;
		uy = 128'(s.ay3) - y1;
		q1 = $signed({97'd0, s.r1});
		q2 = $signed({97'd0, s.r2});
		q3 = $signed({97'd0, s.r3});
		a = q1 * q1 - q2 * q2 + dx * dx + dy * dy;
		b = q1 * q1 - q3 * q3 + ux * ux + uy * uy;
		c = dx * uy - dy * ux;
		f.sat = 1'b0;
		if (c == 0) begin
			f.px = '0;
			f.py = '0;
			f.deg = 1'b1;
			return f;
		end
		f.deg = 1'b0;
		f.px = place_axis(x1, a * uy - b * dy, 2 * c, f.sat);
		f.py = place_axis(y1, b * dx - a * ux, 2 * c, f.sat);
		return f;
	endfunction

	task automatic queue_set(
		input logic signed [31:0] x1, y1, x2, y2, x3, y3,
		input logic [30:0]        r1, r2, r3,
		input logic               drain
	);
		anchor_set_t s;
		s.ax1 = x1; s.ay1 = y1; s.ax2 = x2; s.ay2 = y2; s.ax3 = x3; s.ay3 = y3;
		s.r1 = r1; s.r2 = r2; s.r3 = r3;
		s.hold_drain = drain;
		pending_sets.insert(pending_sets.size(), s);
		queued_sets++;
	endtask

	function automatic logic [30:0] true_range(
		input logic signed [31:0] ax, ay,
		input logic signed [31:0] px, py
	);
		real ddx, ddy, r;
		ddx = $itor(ax) - $itor(px);
		ddy = $itor(ay) - $itor(py);
		r = $sqrt(ddx * ddx + ddy * ddy) + $itor($urandom_range(0, 4096)) - 2048.0;
		if (r < 0.0) r = 0.0;
		if (r > 2147483647.0) r = 2147483647.0;
		return 31'($rtoi(r));
	endfunction

	// Draw one random anchor set; most are plausible geometry around a true position.
	task automatic queue_random(input logic drain);
		logic signed [31:0] x1, y1, x2, y2, x3, y3, px, py;
		int                 pick;
		int                 k;
		pick = $urandom_range(0, 99);
		x1 = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		y1 = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		x2 = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		y2 = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		x3 = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		y3 = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		px = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		py = $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		if (pick < 60) begin
			queue_set(x1, y1, x2, y2, x3, y3, true_range(x1, y1, px, py),
				true_range(x2, y2, px, py), true_range(x3, y3, px, py), drain);
		end else if (pick < 80) begin
			// full-width noise: every bit of every field toggles
			queue_set($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				31'($urandom), 31'($urandom), 31'($urandom), drain);
		end else if (pick < 90) begin
			// collinear: anchor three on the line through anchors one and two
			k = $urandom_range(0, 6) - 3;
			x2 = x1 + $signed($urandom_range(0, 2000)) - 1000;
			y2 = y1 + $signed($urandom_range(0, 2000)) - 1000;
			queue_set(x1, y1, x2, y2, x1 + k * (x2 - x1), y1 + k * (y2 - y1),
				31'($urandom), 31'($urandom), 31'($urandom), drain);
		end else if (pick < 95) begin
			queue_set(x1, y1, x1, y1, x3, y3, 31'($urandom), 31'($urandom),
				31'($urandom), drain);
		end else begin
			// tiny triangle with huge ranges drives the quotient out of range
			queue_set(x1, y1, x1 + 1, y1, x1, y1 + 1, 31'h7FFF_FFFF,
				31'($urandom_range(0, 100)), 31'($urandom_range(0, 100)), drain);
		end
	endtask

	// Driver: present one beat at a time, hold it while stalled, pause as drawn.
	assign in_fire = in_valid && !in_stall;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			// the accepted set leaves the queue here, so the next one is at the front
			if (in_fire) begin
				expected_fixes.insert(expected_fixes.size(),
					solve_position(pending_sets.pop_front()));
				sent_sets <= sent_sets + 1;
			end
			if (!in_valid || in_fire) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_sets.size() > 0 &&
						!(pending_sets[0].hold_drain &&
						(expected_fixes.size() > 0))) begin
					anchor_set_t s;
					s = pending_sets[0];
					anchor_one_x <= s.ax1;
					anchor_one_y <= s.ay1;
					anchor_two_x <= s.ax2;
					anchor_two_y <= s.ay2;
					anchor_three_x <= s.ax3;
					anchor_three_y <= s.ay3;
					range_one <= s.r1;
					range_two <= s.r2;
					range_three <= s.r3;
					in_valid <= 1'b1;
					send_gap <= burst_mode ? 0 : $urandom_range(0, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result beat with the oldest prediction, then draw a stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			stall_draw = stall_left;
			if (out_valid && !out_stall) begin
				if (expected_fixes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat x=%0d y=%0d", position_x, position_y);
				end else begin
					fix_t e;
					e = expected_fixes.pop_front();
					if (e.px !== position_x || e.py !== position_y ||
							e.deg !== degenerate || e.sat !== saturated) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp x=%0d y=%0d deg=%b sat=%b, got x=%0d y=%0d deg=%b sat=%b",
								e.px, e.py, e.deg, e.sat,
								position_x, position_y, degenerate, saturated);
					end
				end
				stall_draw = burst_mode ? 0 : $urandom_range(0, 5);
			end
			if (stall_draw > 0) begin
				stall_left <= stall_draw - 1;
				out_stall <= 1'b1;
			end else begin
				stall_left <= 0;
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		mismatches = 0;
		sent_sets = 0;
		queued_sets = 0;
		burst_mode = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		anchor_one_x = '0; anchor_one_y = '0; anchor_two_x = '0; anchor_two_y = '0;
		anchor_three_x = '0; anchor_three_y = '0;
		range_one = '0; range_two = '0; range_three = '0;

		// Directed: degenerate layouts, field extremes, clipping, an ordinary triangle.
		queue_set(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
		queue_set(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sh0002_0000,
			32'sh0005_0000, 0, 31'h0003_0000, 31'h0003_0000, 31'h0004_0000, 1'b0);
		queue_set(0, 0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0003_0000, 32'sh0003_0000,
			31'h0001_0000, 31'h0001_0000, 31'h0001_0000, 1'b0);
		queue_set(0, 0, 32'sh000A_0000, 0, 0, 32'sh000A_0000,
			31'h0005_0000, 31'h0005_0000, 31'h0005_0000, 1'b0);
		queue_set(0, 0, 32'sh000A_0000, 0, 0, 32'sh000A_0000, 0, 0, 0, 1'b0);
		queue_set(POS_MIN, POS_MIN, POS_MAX, POS_MIN, POS_MIN, POS_MAX,
			31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
		queue_set(POS_MAX, POS_MAX, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 0, 0, 0, 1'b0);
		queue_set(POS_MIN, POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN,
			31'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 1'b0);
		queue_set(0, 0, 1, 0, 0, 1, 31'h7FFF_FFFF, 0, 0, 1'b0);
		queue_set(0, 0, 1, 0, 0, 1, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
		queue_set(POS_MAX, POS_MAX, POS_MAX - 1, POS_MAX, POS_MAX, POS_MAX - 1,
			31'h7FFF_FFFF, 0, 0, 1'b0);
		queue_set(POS_MIN, POS_MIN, POS_MIN + 1, POS_MIN, POS_MIN, POS_MIN + 1,
			31'h7FFF_FFFF, 0, 0, 1'b0);
		queue_set(0, 0, 3, 0, 0, 2, 1, 1, 1, 1'b0);
		queue_set(-32'sh0003_0000, 32'sh0002_0000, 32'sh0004_0000, -32'sh0001_0000,
			32'sh0001_8000, 32'sh0006_0000, 31'h0004_2000, 31'h0005_1000, 31'h0003_F000, 1'b0);
		queue_set(-1, -1, 0, -1, -1, 0, 31'h5555_5555, 31'h2AAA_AAAA, 31'h7FFF_FFFF, 1'b0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Random: bursts with no idling alternate with randomly paced stretches.
		for (int n = 0; n < 700; n++) begin
			if (n % 100 == 0) begin
				wait (pending_sets.size() < 20);
				@(posedge clk);
				burst_mode <= (n % 200 == 100);
			end
			queue_random(n == 50 || n == 400);
			if (pending_sets.size() > 40) wait (pending_sets.size() < 20);
		end

		wait (pending_sets.size() == 0 && sent_sets == queued_sets && !in_valid);
		wait (expected_fixes.size() == 0);
		repeat (LAT + 20) @(posedge clk);
		if (mismatches == 0 && expected_fixes.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
src/tri2d_pkg.sv
src/tri2d_front.sv
src/tri2d_div.sv
src/trilateration_2d_solver.sv
tb/sv/tb.sv
